[sv/drs_pkg.sv]
// drs_pkg: shared types and constants for the descending record sort block.
// Used by drs_ctrl, drs_datapath and descending_record_sort_top. No dependencies.
`timescale 1ns / 1ps

package drs_pkg;

  localparam int TAG_W   = 16;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 6;
  localparam int IN_W    = 48;   // tag + score, whole bytes
  localparam int OUT_W   = 56;   // tag + score + rank, padded to whole bytes

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } record_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_LOADCUR,
    ST_SCAN,
    ST_WB,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_JNEXT,
    RD_K
  } rd_sel_t;

  typedef struct packed {
    logic    accept_en;
    logic    i_clr;
    logic    i_inc;
    logic    j_clr;
    logic    j_inc;
    logic    k_clr;
    logic    k_inc;
    rd_sel_t rd_sel;
    logic    cur_ld;
    logic    scan;
    logic    wb;
    logic    out_ld;
    logic    set_clr;
  } drs_cmd_t;

  typedef struct packed {
    logic in_last_fire;
    logic out_fire;
    logic last_i;
    logic last_j;
    logic last_k;
  } drs_status_t;

endpackage

[sv/descending_record_sort_top.sv]
// descending_record_sort_top: collects records, sorts them by descending score
// with an exchange pass and streams them out ranked. Depends on drs_pkg,
// drs_ctrl and drs_datapath.
//
//  channel | dir | tdata (low bit up)                  | tlast        | tuser
//  in_     | in  | record_tag[15:0], record_score[31:0] | last_record  | -
//  out_    | out | out_tag[15:0], out_score[31:0],      | last_out     | dropped_flag
//          |     | out_rank[5:0], 2 zero bits          |              |
//
// Loading accepts one word per cycle; the word with tlast ends the set.
// The sort then runs N passes (fetch, load of the running record, scan with
// one read per compare on the single record memory, write-back); each result
// is read, registered and held until out_tready. Input is not taken during
// sort and output. Synchronous active-low reset; the memory needs no clearing.
`timescale 1ns / 1ps

module descending_record_sort_top import drs_pkg::*; #(
  parameter int MAX_RECORDS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,    // [15:0] record_tag, [47:16] record_score
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,   // [15:0] tag, [47:16] score, [53:48] rank, [55:54] 0
  output logic             out_tlast,
  output logic             out_tuser    // dropped_flag
);

  drs_cmd_t    cmd;
  drs_status_t status;

  drs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  drs_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // input only during load
  assign in_tready = cmd.accept_en;

  // load and output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // the last word of a set starts the sort
  a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still taken after end of set");

  // after the final result goes, loading resumes
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("no return to load after final result");

  // tlast on a result matches the output counter reaching the set size
  a_last_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == status.last_k))
    else $error("tlast disagrees with output count");

endmodule

[sv/drs_ctrl.sv]
// drs_ctrl: sequencer for load, exchange pass and output of the record sort.
// Depends on drs_pkg (state, command and status types).
`timescale 1ns / 1ps

module drs_ctrl import drs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  drs_status_t status,
  output drs_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (status.in_last_fire) state_nxt = ST_FETCH;
      end
      ST_FETCH:   state_nxt = ST_LOADCUR;
      ST_LOADCUR: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.last_j) state_nxt = ST_WB;
      end
      ST_WB: begin
        state_nxt = status.last_i ? ST_OUT_RD : ST_FETCH;
      end
      ST_OUT_RD: state_nxt = ST_OUT_LD;
      ST_OUT_LD: state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (status.out_fire) state_nxt = status.last_k ? ST_LOAD : ST_OUT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_I;
    case (state_r)
      ST_LOAD: begin
        cmd.accept_en = 1'b1;
        cmd.i_clr     = 1'b1;
      end
      ST_FETCH: begin
        cmd.rd_sel = RD_I;
        cmd.j_clr  = 1'b1;
      end
      ST_LOADCUR: begin
        cmd.cur_ld = 1'b1;
        cmd.rd_sel = RD_J;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.rd_sel = RD_JNEXT;
        cmd.j_inc  = 1'b1;
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        cmd.i_inc = 1'b1;
        cmd.k_clr = 1'b1;
      end
      ST_OUT_RD: begin
        cmd.rd_sel = RD_K;
      end
      ST_OUT_LD: begin
        cmd.out_ld = 1'b1;
      end
      ST_OUT_WAIT: begin
        if (status.out_fire) begin
          cmd.k_inc   = 1'b1;
          cmd.set_clr = status.last_k;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

[sv/drs_datapath.sv]
// drs_datapath: record memory, running record of the exchange pass, counters
// and output register. Depends on drs_pkg; driven by drs_ctrl commands.
`timescale 1ns / 1ps

module drs_datapath import drs_pkg::*; #(
  parameter int MAX_RECORDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  drs_cmd_t          cmd,
  output drs_status_t       status,
  input  logic              in_tvalid,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  record_t mem [MAX_RECORDS];
  record_t rdata_r;
  record_t cur_r, cur_nxt;
  record_t in_rec;
  record_t wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          full, in_fire, swap;

  record_t           out_rec_r, out_rec_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_rec.tag   = in_tdata[TAG_W-1:0];
  assign in_rec.score = in_tdata[TAG_W+SCORE_W-1:TAG_W];

  assign full    = (cnt_r == CW'(MAX_RECORDS));
  assign in_fire = cmd.accept_en && in_tvalid;
  // j == i compares the record with itself: never a swap
  assign swap    = cmd.scan && (j_r != i_r) && ($signed(cur_r.score) > $signed(rdata_r.score));

  assign status.in_last_fire = in_fire && in_tlast;
  assign status.out_fire     = out_valid_r && out_tready;
  assign status.last_i       = (CW'(i_r) + CW'(1)) == cnt_r;
  assign status.last_j       = (CW'(j_r) + CW'(1)) == cnt_r;
  assign status.last_k       = (CW'(k_r) + CW'(1)) == cnt_r;

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = in_rec;
    if (in_fire && !full) begin
      wr_en = 1'b1;
    end else if (swap) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = cur_r;
    end else if (cmd.wb) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_data = cur_r;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_I:     rd_addr = i_r;
      RD_J:     rd_addr = j_r;
      RD_JNEXT: rd_addr = j_r + AW'(1);
      RD_K:     rd_addr = k_r;
      default:  rd_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.cur_ld) cur_nxt = rdata_r;
    else if (swap) cur_nxt = rdata_r;

    i_nxt = i_r;
    if (cmd.i_clr) i_nxt = '0;
    else if (cmd.i_inc) i_nxt = i_r + AW'(1);

    j_nxt = j_r;
    if (cmd.j_clr) j_nxt = '0;
    else if (cmd.j_inc) j_nxt = j_r + AW'(1);

    k_nxt = k_r;
    if (cmd.k_clr) k_nxt = '0;
    else if (cmd.k_inc) k_nxt = k_r + AW'(1);

    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cmd.set_clr) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (in_fire) begin
      if (full) ovf_nxt = 1'b1;
      else      cnt_nxt = cnt_r + CW'(1);
    end

    out_rec_nxt   = out_rec_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_rec_nxt   = rdata_r;
      out_rank_nxt  = RANK_W'(k_r);
      out_last_nxt  = status.last_k;
      out_drop_nxt  = ovf_r;
      out_valid_nxt = 1'b1;
    end else if (status.out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_rec_r  <= out_rec_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-TAG_W-SCORE_W-RANK_W){1'b0}},
                       out_rank_r, out_rec_r.score, out_rec_r.tag};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

endmodule
